/* hdl/test_sweep_sequencer_macros.svh */
// Assertion macros shared by the sweep sequencer modules.
`ifndef TEST_SWEEP_SEQUENCER_MACROS_SVH
`define TEST_SWEEP_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSS_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* hdl/tss_pkg.sv */
`timescale 1ns / 1ps

package tss_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_APPLY = 3'd2,
        PH_WAIT  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [1:0] CFG_DELAY_TICKS    = 2'd0;
    localparam logic [1:0] CFG_FREQ_COUNT     = 2'd1;
    localparam logic [1:0] CFG_DEADTIME_COUNT = 2'd2;
    localparam logic [1:0] CFG_CURRENT_COUNT  = 2'd3;

    localparam logic [15:0] DELAY_RESET = 16'd1000;
    localparam logic [3:0]  COUNT_RESET = 4'd5;

    // Step order: Id+, Id-, Iq+, Iq-.
    localparam logic [1:0] STEP_ID_POS = 2'd0;
    localparam logic [1:0] STEP_ID_NEG = 2'd1;
    localparam logic [1:0] STEP_IQ_POS = 2'd2;
    localparam logic [1:0] STEP_LAST   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  entry_index;
        logic [14:0] entry_value;
    } req_t;

    typedef struct packed {
        logic signed [15:0] id_ref;
        logic signed [15:0] iq_ref;
        logic               loop_enable;
        logic               capture_strobe;
        logic [1:0]         mode_index;
        logic [2:0]         freq_index;
        logic [2:0]         deadtime_index;
        logic [2:0]         current_index;
        logic [1:0]         step_index;
        logic               busy_res;
        logic               sweep_done;
    } res_t;

    // A count of zero acts as one; a count above the maximum saturates.
    function automatic logic [4:0] limit_count(input logic [3:0] count,
                                               input logic [4:0] maxv);
        logic [4:0] ext;
        ext = {1'b0, count};
        if (ext == 5'd0) begin
            return 5'd1;
        end
        if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

endpackage

/* hdl/test_sweep_sequencer.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    req_t: action, entry_index, entry_value
// res       out        res_valid / res_stall    res_t: references, flags, indices
// cfg       in         cfg_valid / cfg_ready    cfg_index (2 bit), cfg_data (16 bit)
//
// On each item's transfer edge the state and the result register load.
// A new item is taken every cycle as long as the result register is empty or being read.
// res_stall stalls req only while a result is held; cfg_ready is always high.
// Reset returns to idle with delay 1000, counts of 5 and a zeroed current table.

module test_sweep_sequencer
    import tss_pkg::*;
#(
    parameter int MAX_CURRENT_POINTS  = 8,
    parameter int MAX_FREQ_POINTS     = 8,
    parameter int MAX_DEADTIME_POINTS = 8,
    parameter int NUM_MODES           = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic accept;
    res_t res_next;

    assign cfg_ready = 1'b1;

    tss_core #(
        .MAX_CURRENT_POINTS  (MAX_CURRENT_POINTS),
        .MAX_FREQ_POINTS     (MAX_FREQ_POINTS),
        .MAX_DEADTIME_POINTS (MAX_DEADTIME_POINTS),
        .NUM_MODES           (NUM_MODES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_next  (res_next)
    );

    tss_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .accept    (accept),
        .res_next  (res_next),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

/* hdl/tss_core.sv */
`timescale 1ns / 1ps

`include "test_sweep_sequencer_macros.svh"

module tss_core
    import tss_pkg::*;
#(
    parameter int MAX_CURRENT_POINTS  = 8,
    parameter int MAX_FREQ_POINTS     = 8,
    parameter int MAX_DEADTIME_POINTS = 8,
    parameter int NUM_MODES           = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  req_t        req,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output res_t        res_next
);

    localparam int CW = (MAX_CURRENT_POINTS > 1) ? $clog2(MAX_CURRENT_POINTS) : 1;
    localparam int FW = (MAX_FREQ_POINTS > 1) ? $clog2(MAX_FREQ_POINTS) : 1;
    localparam int DW = (MAX_DEADTIME_POINTS > 1) ? $clog2(MAX_DEADTIME_POINTS) : 1;
    localparam int MW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;

    localparam logic [4:0] CUR_MAX  = 5'(MAX_CURRENT_POINTS);
    localparam logic [4:0] FREQ_MAX = 5'(MAX_FREQ_POINTS);
    localparam logic [4:0] DEAD_MAX = 5'(MAX_DEADTIME_POINTS);
    localparam logic [4:0] MODE_MAX = 5'(NUM_MODES);

    logic [15:0] delay_reg;
    logic [3:0]  freq_cnt_reg;
    logic [3:0]  dead_cnt_reg;
    logic [3:0]  cur_cnt_reg;

    phase_t      phase_reg, phase_next;
    logic [MW-1:0] mode_reg, mode_next;
    logic [FW-1:0] freq_reg, freq_next;
    logic [DW-1:0] dead_reg, dead_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [1:0]  step_reg, step_next;
    logic [15:0] wait_cnt_reg, wait_cnt_next;
    logic        done_reg, done_next;
    logic        enable_reg, enable_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] iq_reg, iq_next;

    logic [14:0] table_reg [MAX_CURRENT_POINTS];

    logic [4:0]  cur_inc, freq_inc, dead_inc, mode_inc;
    logic [15:0] mag, neg;
    logic        strobe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RESET;
            freq_cnt_reg <= COUNT_RESET;
            dead_cnt_reg <= COUNT_RESET;
            cur_cnt_reg  <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DELAY_TICKS:    delay_reg    <= cfg_data;
                CFG_FREQ_COUNT:     freq_cnt_reg <= cfg_data[3:0];
                CFG_DEADTIME_COUNT: dead_cnt_reg <= cfg_data[3:0];
                CFG_CURRENT_COUNT:  cur_cnt_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CURRENT_POINTS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (accept && req.action == ACT_WRITE &&
                 {2'b00, req.entry_index} < CUR_MAX)
        begin
            table_reg[CW'(req.entry_index)] <= req.entry_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            mode_reg     <= '0;
            freq_reg     <= '0;
            dead_reg     <= '0;
            cur_reg      <= '0;
            step_reg     <= '0;
            wait_cnt_reg <= '0;
            done_reg     <= 1'b0;
            enable_reg   <= 1'b0;
            id_reg       <= '0;
            iq_reg       <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            mode_reg     <= mode_next;
            freq_reg     <= freq_next;
            dead_reg     <= dead_next;
            cur_reg      <= cur_next;
            step_reg     <= step_next;
            wait_cnt_reg <= wait_cnt_next;
            done_reg     <= done_next;
            enable_reg   <= enable_next;
            id_reg       <= id_next;
            iq_reg       <= iq_next;
        end
    end

    assign cur_inc  = 5'(cur_reg) + 5'd1;
    assign freq_inc = 5'(freq_reg) + 5'd1;
    assign dead_inc = 5'(dead_reg) + 5'd1;
    assign mode_inc = 5'(mode_reg) + 5'd1;

    assign mag = {1'b0, table_reg[cur_reg]};
    assign neg = 16'd0 - mag;

    always_comb
    begin
        phase_next    = phase_reg;
        mode_next     = mode_reg;
        freq_next     = freq_reg;
        dead_next     = dead_reg;
        cur_next      = cur_reg;
        step_next     = step_reg;
        wait_cnt_next = wait_cnt_reg;
        done_next     = done_reg;
        enable_next   = enable_reg;
        id_next       = id_reg;
        iq_next       = iq_reg;
        strobe        = 1'b0;

        if (accept && req.action == ACT_START)
        begin
            mode_next  = '0;
            freq_next  = '0;
            dead_next  = '0;
            cur_next   = '0;
            step_next  = '0;
            done_next  = 1'b0;
            phase_next = PH_SETUP;
        end
        else if (accept && req.action == ACT_TICK)
        begin
            case (phase_reg)
                PH_IDLE: ;
                PH_SETUP:
                begin
                    enable_next = 1'b1;
                    id_next     = '0;
                    iq_next     = '0;
                    phase_next  = PH_APPLY;
                end
                PH_APPLY:
                begin
                    id_next = '0;
                    iq_next = '0;
                    case (step_reg)
                        STEP_ID_POS: id_next = mag;
                        STEP_ID_NEG: id_next = neg;
                        STEP_IQ_POS: iq_next = mag;
                        default:     iq_next = neg;
                    endcase
                    wait_cnt_next = '0;
                    phase_next    = PH_WAIT;
                end
                PH_WAIT:
                begin
                    if (wait_cnt_reg >= delay_reg)
                    begin
                        strobe     = 1'b1;
                        phase_next = PH_APPLY;
                        // Odometer: step, current, dead time, frequency, mode.
                        if (step_reg != STEP_LAST)
                        begin
                            step_next = step_reg + 2'd1;
                        end
                        else
                        begin
                            step_next = '0;
                            if (cur_inc < limit_count(cur_cnt_reg, CUR_MAX))
                            begin
                                cur_next = CW'(cur_inc);
                            end
                            else
                            begin
                                cur_next = '0;
                                if (dead_inc < limit_count(dead_cnt_reg, DEAD_MAX))
                                begin
                                    dead_next = DW'(dead_inc);
                                end
                                else
                                begin
                                    dead_next = '0;
                                    if (freq_inc < limit_count(freq_cnt_reg, FREQ_MAX))
                                    begin
                                        freq_next = FW'(freq_inc);
                                    end
                                    else
                                    begin
                                        freq_next = '0;
                                        if (mode_inc < MODE_MAX)
                                        begin
                                            mode_next = MW'(mode_inc);
                                        end
                                        else
                                        begin
                                            mode_next  = '0;
                                            phase_next = PH_DONE;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    else
                    begin
                        wait_cnt_next = wait_cnt_reg + 16'd1;
                    end
                end
                PH_DONE:
                begin
                    id_next     = '0;
                    iq_next     = '0;
                    enable_next = 1'b0;
                    done_next   = 1'b1;
                    phase_next  = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        res_next.id_ref         = id_next;
        res_next.iq_ref         = iq_next;
        res_next.loop_enable    = enable_next;
        res_next.capture_strobe = strobe;
        // On the capture tick the result shows the point just captured.
        res_next.mode_index     = strobe ? 2'(mode_reg) : 2'(mode_next);
        res_next.freq_index     = strobe ? 3'(freq_reg) : 3'(freq_next);
        res_next.deadtime_index = strobe ? 3'(dead_reg) : 3'(dead_next);
        res_next.current_index  = strobe ? 3'(cur_reg) : 3'(cur_next);
        res_next.step_index     = strobe ? step_reg : step_next;
        res_next.busy_res       = (phase_next != PH_IDLE);
        res_next.sweep_done     = done_next;
    end

    `TSS_ASSERT_NEXT(a_start_enters_setup, clk, rst_n,
        accept && req.action == ACT_START, phase_reg == PH_SETUP,
        "start transfer did not enter setup")
    `TSS_ASSERT_IMPL(a_idle_loop_off, clk, rst_n,
        phase_reg == PH_IDLE, !enable_reg,
        "loop enabled while sequencer idle")

endmodule

/* hdl/tss_out_reg.sv */
`timescale 1ns / 1ps

`include "test_sweep_sequencer_macros.svh"

module tss_out_reg
    import tss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic accept,
    input  res_t res_next,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic res_valid_reg, res_valid_next;
    res_t res_reg;

    // A new item may enter whenever the held result leaves in the same cycle.
    assign req_stall      = res_valid_reg && res_stall;
    assign accept         = req_valid && !req_stall;
    assign res_valid_next = accept || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `TSS_ASSERT_NEXT(a_accept_gives_result, clk, rst_n,
        accept, res_valid_reg,
        "accepted item produced no result")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tss_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int POINTS_MAX = 8;
    localparam int SWEEP_MODES = 4;
    localparam int SWEEP_STEPS = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 92;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_index;
        logic [15:0] reg_value;
        req_t        item;
        bit          typed;
        res_t        typed_res;
    } script_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Shadow of the sequencer state, advanced once per accepted transfer.
    phase_t      sw_phase = PH_IDLE;
    logic [1:0]  sw_mode = '0;
    logic [2:0]  sw_freq = '0;
    logic [2:0]  sw_dead = '0;
    logic [2:0]  sw_cur = '0;
    logic [1:0]  sw_step = '0;
    logic [15:0] sw_dwell = '0;
    logic        sw_done = 1'b0;
    logic        sw_enable = 1'b0;
    logic [15:0] sw_id = '0;
    logic [15:0] sw_iq = '0;
    logic [14:0] mag_table [POINTS_MAX] = '{default: '0};

    logic [15:0] delay_setting = DELAY_RESET;
    logic [3:0]  freq_setting = COUNT_RESET;
    logic [3:0]  dead_setting = COUNT_RESET;
    logic [3:0]  cur_setting = COUNT_RESET;

    res_t        results_due[$];
    script_row_t script[$];
    int          failures = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;

    test_sweep_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("test_sweep_sequencer verification failed");
        $finish;
    end

    // A count of zero still sweeps point 0; counts above the table size saturate.
    function automatic int points_in_use(logic [3:0] count);
        if (count == 4'd0)
        begin
            return 1;
        end
        if (int'(count) > POINTS_MAX)
        begin
            return POINTS_MAX;
        end
        return int'(count);
    endfunction

    // Steps the sweep indices like an odometer; returns 1 when the sweep is complete.
    function automatic bit step_odometer();
        if (int'(sw_step) + 1 < SWEEP_STEPS)
        begin
            sw_step = sw_step + 2'd1;
            return 1'b0;
        end
        sw_step = '0;
        if (int'(sw_cur) + 1 < points_in_use(cur_setting))
        begin
            sw_cur = sw_cur + 3'd1;
            return 1'b0;
        end
        sw_cur = '0;
        if (int'(sw_dead) + 1 < points_in_use(dead_setting))
        begin
            sw_dead = sw_dead + 3'd1;
            return 1'b0;
        end
        sw_dead = '0;
        if (int'(sw_freq) + 1 < points_in_use(freq_setting))
        begin
            sw_freq = sw_freq + 3'd1;
            return 1'b0;
        end
        sw_freq = '0;
        if (int'(sw_mode) + 1 < SWEEP_MODES)
        begin
            sw_mode = sw_mode + 2'd1;
            return 1'b0;
        end
        sw_mode = '0;
        return 1'b1;
    endfunction

    function automatic res_t predict_sweep_result(req_t item);
        res_t        r;
        logic        strobe;
        logic [15:0] mag;
        logic [1:0]  cap_mode;
        logic [2:0]  cap_freq;
        logic [2:0]  cap_dead;
        logic [2:0]  cap_cur;
        logic [1:0]  cap_step;
        strobe = 1'b0;
        cap_mode = sw_mode;
        cap_freq = sw_freq;
        cap_dead = sw_dead;
        cap_cur = sw_cur;
        cap_step = sw_step;
        case (item.action)
            ACT_START:
            begin
                sw_mode = '0;
                sw_freq = '0;
                sw_dead = '0;
                sw_cur = '0;
                sw_step = '0;
                sw_done = 1'b0;
                sw_phase = PH_SETUP;
            end
            ACT_WRITE:
            begin
                mag_table[item.entry_index] = item.entry_value;
            end
            ACT_TICK:
            begin
                case (sw_phase)
                    PH_SETUP:
                    begin
                        sw_enable = 1'b1;
                        sw_id = '0;
                        sw_iq = '0;
                        sw_phase = PH_APPLY;
                    end
                    PH_APPLY:
                    begin
                        mag = {1'b0, mag_table[sw_cur]};
                        sw_id = '0;
                        sw_iq = '0;
                        case (sw_step)
                            STEP_ID_POS: sw_id = mag;
                            STEP_ID_NEG: sw_id = -mag;
                            STEP_IQ_POS: sw_iq = mag;
                            default:     sw_iq = -mag;
                        endcase
                        sw_dwell = '0;
                        sw_phase = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        if (sw_dwell >= delay_setting)
                        begin
                            strobe = 1'b1;
                            sw_phase = step_odometer() ? PH_DONE : PH_APPLY;
                        end
                        else
                        begin
                            sw_dwell = sw_dwell + 16'd1;
                        end
                    end
                    PH_DONE:
                    begin
                        sw_id = '0;
                        sw_iq = '0;
                        sw_enable = 1'b0;
                        sw_done = 1'b1;
                        sw_phase = PH_IDLE;
                    end
                    default:
                    begin
                        sw_phase = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        // On the capture tick the indices show the point just captured.
        if (!strobe)
        begin
            cap_mode = sw_mode;
            cap_freq = sw_freq;
            cap_dead = sw_dead;
            cap_cur = sw_cur;
            cap_step = sw_step;
        end
        r.id_ref = sw_id;
        r.iq_ref = sw_iq;
        r.loop_enable = sw_enable;
        r.capture_strobe = strobe;
        r.mode_index = cap_mode;
        r.freq_index = cap_freq;
        r.deadtime_index = cap_dead;
        r.current_index = cap_cur;
        r.step_index = cap_step;
        r.busy_res = (sw_phase != PH_IDLE);
        r.sweep_done = sw_done;
        return r;
    endfunction

    function automatic string fmt_res(res_t r);
        return $sformatf("id=%h iq=%h en=%b cap=%b m=%0d f=%0d d=%0d c=%0d s=%0d busy=%b done=%b",
                         r.id_ref, r.iq_ref, r.loop_enable, r.capture_strobe, r.mode_index,
                         r.freq_index, r.deadtime_index, r.current_index, r.step_index,
                         r.busy_res, r.sweep_done);
    endfunction

    function automatic req_t mk_req(logic [1:0] action, logic [2:0] idx, logic [14:0] value);
        req_t it;
        it.action = action;
        it.entry_index = idx;
        it.entry_value = value;
        return it;
    endfunction

    function automatic res_t quiet_res(logic busy, logic enable, logic [15:0] id);
        res_t r;
        r = '0;
        r.busy_res = busy;
        r.loop_enable = enable;
        r.id_ref = id;
        return r;
    endfunction

    function automatic void add_item(req_t it, bit typed, res_t want);
        script_row_t row;
        row = '{default: '0};
        row.item = it;
        row.typed = typed;
        row.typed_res = want;
        script.push_back(row);
    endfunction

    function automatic void add_write(logic [1:0] idx, logic [15:0] value);
        script_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        script.push_back(row);
    endfunction

    function automatic logic [3:0] random_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return 4'($urandom_range(0, 1));
        end
        if (roll < 90)
        begin
            return 4'd2;
        end
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [15:0] random_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 16'd0;
        end
        if (roll < 90)
        begin
            return 16'($urandom_range(1, 3));
        end
        return 16'($urandom_range(4, 40));
    endfunction

    // Mostly ticks that walk the sweep, with restarts, table writes and unused codes mixed in.
    function automatic req_t random_item();
        int          roll;
        logic [2:0]  idx;
        logic [14:0] value;
        roll = $urandom_range(0, 99);
        idx = 3'($urandom_range(0, 7));
        value = 15'($urandom_range(0, 32767));
        if (sw_phase == PH_IDLE && roll < 60)
        begin
            return mk_req(ACT_START, idx, value);
        end
        if (roll < 3)
        begin
            return mk_req(ACT_START, idx, value);
        end
        if (roll < 9)
        begin
            return mk_req(ACT_WRITE, idx, value);
        end
        if (roll < 11)
        begin
            return mk_req(ACT_UNUSED, idx, value);
        end
        return mk_req(ACT_TICK, idx, value);
    endfunction

    task automatic send_item(req_t it, bit typed, res_t typed_res);
        res_t want;
        if (idle_on && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        want = predict_sweep_result(it);
        if (typed)
        begin
            want = typed_res;
        end
        results_due.push_back(want);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DELAY_TICKS:    delay_setting = value;
            CFG_FREQ_COUNT:     freq_setting = value[3:0];
            CFG_DEADTIME_COUNT: dead_setting = value[3:0];
            default:            cur_setting = value[3:0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [15:0] delay, logic [3:0] freq, logic [3:0] dead,
                             logic [3:0] cur);
        drain();
        repeat (3) @(posedge clk);
        write_reg(CFG_DELAY_TICKS, delay);
        write_reg(CFG_FREQ_COUNT, {12'd0, freq});
        write_reg(CFG_DEADTIME_COUNT, {12'd0, dead});
        write_reg(CFG_CURRENT_COUNT, {12'd0, cur});
    endtask

    // Result side: check every transfer against the oldest prediction, stall in bursts.
    always @(posedge clk)
    begin : result_check
        res_t want;
        bit   bad;
        if (rst_n && res_valid && !res_stall)
        begin
            if (results_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("unexpected result: %s", fmt_res(res));
                end
            end
            else
            begin
                want = results_due.pop_front();
                bad = (res.id_ref !== want.id_ref) || (res.iq_ref !== want.iq_ref)
                      || (res.loop_enable !== want.loop_enable)
                      || (res.capture_strobe !== want.capture_strobe)
                      || (res.mode_index !== want.mode_index)
                      || (res.freq_index !== want.freq_index)
                      || (res.deadtime_index !== want.deadtime_index)
                      || (res.current_index !== want.current_index)
                      || (res.step_index !== want.step_index)
                      || (res.busy_res !== want.busy_res)
                      || (res.sweep_done !== want.sweep_done);
                if (bad)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("mismatch: expected %s", fmt_res(want));
                        $display("          actual   %s", fmt_res(res));
                    end
                end
            end
        end
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < 8)
        begin
            stall_left <= $urandom_range(0, 14);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int   useful;
        req_t it;
        bit   ignored;

        // Idle block with reset settings: nothing moves until a start.
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b1, quiet_res(1'b0, 1'b0, 16'd0));
        add_item(mk_req(ACT_UNUSED, 3'd7, 15'h7FFF), 1'b1, quiet_res(1'b0, 1'b0, 16'd0));
        add_item(mk_req(ACT_WRITE, 3'd0, 15'h7FFF), 1'b1, quiet_res(1'b0, 1'b0, 16'd0));
        add_item(mk_req(ACT_WRITE, 3'd7, 15'h0000), 1'b1, quiet_res(1'b0, 1'b0, 16'd0));
        add_item(mk_req(ACT_WRITE, 3'd1, 15'h0001), 1'b1, quiet_res(1'b0, 1'b0, 16'd0));
        add_item(mk_req(ACT_WRITE, 3'd2, 15'h5555), 1'b1, quiet_res(1'b0, 1'b0, 16'd0));
        add_item(mk_req(ACT_START, 3'd5, 15'h2AAA), 1'b1, quiet_res(1'b1, 1'b0, 16'd0));
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b1, quiet_res(1'b1, 1'b1, 16'd0));
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b1, quiet_res(1'b1, 1'b1, 16'h7FFF));
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        // Restart while running keeps the references until the setup tick.
        add_item(mk_req(ACT_START, 3'd0, 15'd0), 1'b0, '0);
        add_write(CFG_DELAY_TICKS, 16'd0);
        add_write(CFG_CURRENT_COUNT, 16'd0);
        add_write(CFG_FREQ_COUNT, 16'd15);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        // Zero delay: the first wait tick already captures.
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        // A table write mid-sweep shows up at the next apply.
        add_item(mk_req(ACT_WRITE, 3'd0, 15'h0100), 1'b0, '0);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        add_item(mk_req(ACT_TICK, 3'd0, 15'd0), 1'b0, '0);
        add_item(mk_req(ACT_WRITE, 3'd7, 15'h7FFF), 1'b0, '0);
        add_item(mk_req(ACT_UNUSED, 3'd0, 15'd0), 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain();
                repeat (3) @(posedge clk);
                write_reg(script[i].reg_index, script[i].reg_value);
            end
            else
            begin
                send_item(script[i].item, script[i].typed, script[i].typed_res);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on = (p != 2) && (p < RANDOM_PHASES - 2);
            case (p)
                0:                 configure(16'hFFFF, 4'd8, 4'd15, 4'd8);
                1:                 configure(16'd0, 4'd0, 4'd0, 4'd0);
                5:                 configure(16'd1, 4'd8, 4'd1, 4'd1);
                RANDOM_PHASES - 1: configure(16'd0, 4'd1, 4'd1, 4'd1);
                default:           configure(random_delay(), random_count(), random_count(),
                                             random_count());
            endcase
            send_item(mk_req(ACT_START, 3'($urandom_range(0, 7)),
                             15'($urandom_range(0, 32767))), 1'b0, '0);
            useful = 1;
            while (useful < PHASE_ITEMS)
            begin
                if (p == 4 && useful == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                it = random_item();
                ignored = (it.action == ACT_UNUSED)
                          || (it.action == ACT_TICK && sw_phase == PH_IDLE);
                if (!ignored)
                begin
                    useful++;
                end
                send_item(it, 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("test_sweep_sequencer verification clean");
        end
        else
        begin
            $display("test_sweep_sequencer verification failed");
        end
        $finish;
    end

endmodule
